@@ rtl/ftgf_pkg.sv @@
// Shared types and constants for the fingerprint tap gesture filter.
`default_nettype none

package ftgf_pkg;

    // Command codes of an input word
    localparam logic [1:0] CMD_OTHER = 2'd0;
    localparam logic [1:0] CMD_KEY   = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // Key values of a key event; any nonzero value counts as a press
    localparam logic [1:0] KEY_RELEASE = 2'd0;
    localparam logic [1:0] KEY_PRESS   = 2'd1;
    localparam logic [1:0] KEY_REPEAT  = 2'd2;

    // Operating modes
    localparam logic [1:0] MODE_PASS  = 2'd0;
    localparam logic [1:0] MODE_HOME  = 2'd1;
    localparam logic [1:0] MODE_TAP   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_WAIT   = 2'd1;
    localparam logic [1:0] CFG_VIB    = 2'd2;

    // Register limits, reset values and fallbacks for out-of-range writes
    localparam logic [1:0] MODE_RESET   = MODE_TAP;
    localparam logic [3:0] WAIT_MAX     = 4'd9;
    localparam logic [3:0] WAIT_RESET   = 4'd2;
    localparam logic [6:0] VIB_MAX      = 7'd90;
    localparam logic [6:0] VIB_RESET    = 7'd20;

    localparam logic [4:0] TICK_MAX     = 5'd31;

    typedef struct packed {
        logic       window_active;
        logic [4:0] window_ticks;
        logic       break_request;
        logic       home_sent;
        logic       release_pending;
        logic       finger_down;
        logic       off_while_down;
    } t_state;

    localparam t_state STATE_RESET = '{
        window_active:   1'b0,
        window_ticks:    5'd0,
        break_request:   1'b1,
        home_sent:       1'b0,
        release_pending: 1'b0,
        finger_down:     1'b0,
        off_while_down:  1'b0
    };

    typedef struct packed {
        logic pass_through;
        logic home_press;
        logic home_release;
        logic power_pulse;
        logic vibrate;
    } t_flags;

endpackage

`default_nettype wire

@@ rtl/ftgf_step.sv @@
// Next-state and result logic for one word of the tap filter.
`default_nettype none

module ftgf_step #(
    parameter int WINDOW_BASE = 12
) (
    input  wire ftgf_pkg::t_state i_state,
    input  wire [1:0]             i_mode,
    input  wire [3:0]             i_wait_period,
    input  wire [1:0]             i_cmd,
    input  wire [1:0]             i_key_value,
    input  wire                   i_display_on,
    output ftgf_pkg::t_state      o_state,
    output ftgf_pkg::t_flags      o_flags
);

    logic [5:0] w_limit;
    logic [4:0] w_ticks_inc;
    logic       w_press;

    assign w_limit     = 6'(WINDOW_BASE) + {2'b00, i_wait_period};
    assign w_ticks_inc = (i_state.window_ticks < ftgf_pkg::TICK_MAX) ?
                         i_state.window_ticks + 5'd1 : i_state.window_ticks;
    assign w_press     = (i_key_value != ftgf_pkg::KEY_RELEASE);

    always_comb begin
        o_state = i_state;
        o_flags = '0;
        if (i_cmd == ftgf_pkg::CMD_TICK) begin
            if (i_state.window_active) begin
                if (i_state.break_request) begin
                    o_state.window_active = 1'b0;
                end else begin
                    o_state.window_ticks = w_ticks_inc;
                    if ({1'b0, w_ticks_inc} >= w_limit) begin
                        o_state.window_active = 1'b0;
                        o_state.home_sent     = 1'b1;
                        o_flags.home_press    = 1'b1;
                        if (i_state.release_pending) begin
                            o_flags.home_release    = 1'b1;
                            o_state.release_pending = 1'b0;
                        end
                    end
                end
            end
        end else if (i_cmd != ftgf_pkg::CMD_KEY || i_mode == ftgf_pkg::MODE_PASS) begin
            o_flags.pass_through = 1'b1;
        end else if (i_mode == ftgf_pkg::MODE_TAP) begin
            if (w_press) begin
                if (!i_display_on) begin
                    o_flags.pass_through = 1'b1;
                end else begin
                    o_state.finger_down   = 1'b1;
                    o_state.home_sent     = 1'b0;
                    o_state.break_request = 1'b1;
                    o_flags.vibrate       = 1'b1;
                    if (i_state.window_active) begin
                        // double tap: window stays open until the next tick
                        o_state.off_while_down  = 1'b1;
                        o_state.release_pending = 1'b0;
                        o_flags.power_pulse     = 1'b1;
                    end else begin
                        o_state.window_active = 1'b1;
                        o_state.window_ticks  = 5'd0;
                        o_state.break_request = 1'b0;
                    end
                end
            end else if (i_state.finger_down) begin
                if (!i_display_on) begin
                    o_state.off_while_down = 1'b0;
                    o_flags.pass_through   = 1'b1;
                end else begin
                    o_state.finger_down = 1'b0;
                    if (i_state.home_sent) begin
                        o_flags.home_release = 1'b1;
                    end else begin
                        o_state.release_pending = 1'b1;
                    end
                end
            end else begin
                o_flags.pass_through = 1'b1;
            end
        end else begin
            if (!i_display_on) begin
                o_flags.pass_through = 1'b1;
            end else if (w_press) begin
                o_flags.vibrate    = 1'b1;
                o_flags.home_press = 1'b1;
            end else begin
                o_flags.home_release = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/fingerprint_tap_gesture_filter.sv @@
// Top level of the fingerprint tap gesture filter: handshake, config and state.
// A word accepted at an edge has its result word registered at that same edge.
// Throughput: one word per cycle while o_stall is low; filter state updated at acceptance.
// A result register plus one skid entry lets input run while the result side
// stalls; o_stall rises only when both entries are full.
// Synchronous active-low reset clears handshake and filter state and loads
// the configuration defaults (mode 2, wait period 2, strength 20).
`default_nettype none

module fingerprint_tap_gesture_filter #(
    parameter int WINDOW_BASE = 12
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    // config write port
    input  wire        i_cfg_we,
    input  wire [1:0]  i_cfg_idx,
    input  wire [6:0]  i_cfg_data,
    // input channel
    input  wire        i_valid,
    output logic       o_stall,
    input  wire [1:0]  i_cmd,
    input  wire [1:0]  i_key_value,
    input  wire        i_display_on,
    // result channel
    output logic       o_valid,
    input  wire        i_stall,
    output logic       o_pass_through,
    output logic       o_home_press,
    output logic       o_home_release,
    output logic       o_power_pulse,
    output logic       o_vibrate,
    output logic [6:0] o_vibrate_strength
);

    // Configuration registers
    logic [1:0] r_mode;
    logic [3:0] r_wait_period;
    logic [6:0] r_vib_strength;

    // Filter state
    ftgf_pkg::t_state r_state;
    ftgf_pkg::t_state n_state;
    ftgf_pkg::t_flags w_flags;

    // Output register and skid entry
    logic             r_out_valid;
    ftgf_pkg::t_flags r_out_flags;
    logic [6:0]       r_out_strength;
    logic             r_skid_valid;
    ftgf_pkg::t_flags r_skid_flags;
    logic [6:0]       r_skid_strength;

    logic w_in_take;
    logic w_out_take;
    logic w_out_free;

    assign w_in_take  = i_valid && !r_skid_valid;
    assign w_out_take = r_out_valid && !i_stall;
    assign w_out_free = !r_out_valid || w_out_take;

    ftgf_step #(
        .WINDOW_BASE (WINDOW_BASE)
    ) u_step (
        .i_state       (r_state),
        .i_mode        (r_mode),
        .i_wait_period (r_wait_period),
        .i_cmd         (i_cmd),
        .i_key_value   (i_key_value),
        .i_display_on  (i_display_on),
        .o_state       (n_state),
        .o_flags       (w_flags)
    );

    // Config writes: clamp out-of-range values to their fallbacks, drop unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= ftgf_pkg::MODE_RESET;
            r_wait_period  <= ftgf_pkg::WAIT_RESET;
            r_vib_strength <= ftgf_pkg::VIB_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ftgf_pkg::CFG_MODE: begin
                    r_mode <= (i_cfg_data[1:0] > ftgf_pkg::MODE_TAP) ?
                              ftgf_pkg::MODE_PASS : i_cfg_data[1:0];
                end
                ftgf_pkg::CFG_WAIT: begin
                    r_wait_period <= (i_cfg_data[3:0] > ftgf_pkg::WAIT_MAX) ?
                                     ftgf_pkg::WAIT_RESET : i_cfg_data[3:0];
                end
                ftgf_pkg::CFG_VIB: begin
                    r_vib_strength <= (i_cfg_data > ftgf_pkg::VIB_MAX) ?
                                      ftgf_pkg::VIB_RESET : i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Advance filter state on every accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ftgf_pkg::STATE_RESET;
        end else if (w_in_take) begin
            r_state <= n_state;
        end
    end

    // Output stage control: the skid entry always drains into the output register first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= w_in_take;
            end else begin
                r_out_valid  <= w_in_take;
            end
        end else if (w_in_take) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Output stage payload
    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_skid_valid) begin
                r_out_flags    <= r_skid_flags;
                r_out_strength <= r_skid_strength;
                if (w_in_take) begin
                    r_skid_flags    <= w_flags;
                    r_skid_strength <= r_vib_strength;
                end
            end else if (w_in_take) begin
                r_out_flags    <= w_flags;
                r_out_strength <= r_vib_strength;
            end
        end else if (w_in_take) begin
            r_skid_flags    <= w_flags;
            r_skid_strength <= r_vib_strength;
        end
    end

    assign o_stall            = r_skid_valid;
    assign o_valid            = r_out_valid;
    assign o_pass_through     = r_out_flags.pass_through;
    assign o_home_press       = r_out_flags.home_press;
    assign o_home_release     = r_out_flags.home_release;
    assign o_power_pulse      = r_out_flags.power_pulse;
    assign o_vibrate          = r_out_flags.vibrate;
    assign o_vibrate_strength = r_out_strength;

    // The skid entry is only filled behind a waiting result word
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid without output word");

    // A passed-through word never carries a generated key
    a_pass_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_pass_through) |->
            (!o_home_press && !o_home_release && !o_power_pulse && !o_vibrate))
        else $error("pass-through word carries generated keys");

    // Power pulse only on a double tap, which also asks for vibration
    a_pwr_vib: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_power_pulse) |-> (o_vibrate && !o_home_press))
        else $error("power pulse without vibration");

    // Clamped configuration never holds an out-of-range value
    a_cfg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode <= ftgf_pkg::MODE_TAP) && (r_wait_period <= ftgf_pkg::WAIT_MAX)
            && (r_vib_strength <= ftgf_pkg::VIB_MAX))
        else $error("configuration register out of range");

    // A newly opened window starts counting from zero
    a_window_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_state.window_active ##1 r_state.window_active) |->
            (r_state.window_ticks == 5'd0 && !r_state.break_request))
        else $error("window opened with stale count");

endmodule

`default_nettype wire

@@ tb/tb_fingerprint_tap_gesture_filter.sv @@
// Self-checking testbench for the fingerprint tap gesture filter: random gestures, stalls, config.
`timescale 1ns / 1ps

module tb_fingerprint_tap_gesture_filter;

    localparam int          TAP_WINDOW_BASE = 12;
    localparam int          CYCLE_LIMIT     = 400000;
    localparam int          PHASE_WORDS     = 70;
    localparam int          NUM_PHASES      = 8;

    // Codes the package does not name
    localparam logic [1:0]  CMD_SPARE   = 2'd3;
    localparam logic [1:0]  CFG_SPARE   = 2'd3;
    localparam logic [1:0]  KEY_ODD     = 2'd3;

    typedef struct packed {
        logic [1:0] cmd;
        logic [1:0] key;
        logic       disp;
    } t_sensor_event;

    typedef struct packed {
        ftgf_pkg::t_flags flags;
        logic [6:0]       strength;
    } t_key_action;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = 2'd0;
    logic [6:0] i_cfg_data = 7'd0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [1:0] i_cmd = 2'd0;
    logic [1:0] i_key_value = 2'd0;
    logic       i_display_on = 1'b0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic       o_pass_through;
    logic       o_home_press;
    logic       o_home_release;
    logic       o_power_pulse;
    logic       o_vibrate;
    logic [6:0] o_vibrate_strength;

    fingerprint_tap_gesture_filter #(
        .WINDOW_BASE(TAP_WINDOW_BASE)
    ) u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_cmd              (i_cmd),
        .i_key_value        (i_key_value),
        .i_display_on       (i_display_on),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_pass_through     (o_pass_through),
        .o_home_press       (o_home_press),
        .o_home_release     (o_home_release),
        .o_power_pulse      (o_power_pulse),
        .o_vibrate          (o_vibrate),
        .o_vibrate_strength (o_vibrate_strength)
    );

    // Queues between the stimulus, the driver and the checker
    t_sensor_event queued_events[$];
    t_key_action   expected_actions[$];

    // Shadow copy of the filter configuration and state
    logic [1:0]       mode_cfg;
    logic [3:0]       wait_cfg;
    logic [6:0]       vib_cfg;
    ftgf_pkg::t_state gesture;

    // Driver and stall control
    t_sensor_event word_on_bus;
    int            send_gap = 0;
    int            stall_left = 0;
    bit            sender_idles = 1'b1;
    bit            receiver_stalls = 1'b1;

    int            mismatches = 0;
    int            results_seen = 0;
    int            cycle_count = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Gap length: mostly none, often short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    // Mirror a register write, with its clamping of out-of-range values
    function automatic void store_setting(input logic [1:0] idx, input logic [6:0] data);
        case (idx)
            ftgf_pkg::CFG_MODE:
                mode_cfg = (data[1:0] > ftgf_pkg::MODE_TAP) ? ftgf_pkg::MODE_PASS : data[1:0];
            ftgf_pkg::CFG_WAIT:
                wait_cfg = (data[3:0] > ftgf_pkg::WAIT_MAX) ? ftgf_pkg::WAIT_RESET : data[3:0];
            ftgf_pkg::CFG_VIB:
                vib_cfg  = (data > ftgf_pkg::VIB_MAX) ? ftgf_pkg::VIB_RESET : data;
            default: ;
        endcase
    endfunction

    // Work out the action word for one sensor event and advance the shadow state
    function automatic t_key_action predict_gesture(input t_sensor_event ev);
        t_key_action act;
        logic        press;
        logic [4:0]  limit;
        act.flags    = '0;
        act.strength = vib_cfg;
        press        = (ev.key != ftgf_pkg::KEY_RELEASE);
        limit        = 5'(TAP_WINDOW_BASE) + {1'b0, wait_cfg};
        if (ev.cmd == ftgf_pkg::CMD_TICK) begin
            if (gesture.window_active) begin
                if (gesture.break_request) begin
                    // second press already handled: close silently
                    gesture.window_active = 1'b0;
                end else begin
                    if (gesture.window_ticks != ftgf_pkg::TICK_MAX)
                        gesture.window_ticks = gesture.window_ticks + 5'd1;
                    if (gesture.window_ticks >= limit) begin
                        gesture.window_active = 1'b0;
                        gesture.home_sent     = 1'b1;
                        act.flags.home_press  = 1'b1;
                        if (gesture.release_pending) begin
                            act.flags.home_release  = 1'b1;
                            gesture.release_pending = 1'b0;
                        end
                    end
                end
            end
        end else if (ev.cmd != ftgf_pkg::CMD_KEY || mode_cfg == ftgf_pkg::MODE_PASS) begin
            act.flags.pass_through = 1'b1;
        end else if (mode_cfg == ftgf_pkg::MODE_TAP) begin
            if (press) begin
                if (!ev.disp) begin
                    act.flags.pass_through = 1'b1;
                end else begin
                    gesture.finger_down   = 1'b1;
                    gesture.home_sent     = 1'b0;
                    gesture.break_request = 1'b1;
                    act.flags.vibrate     = 1'b1;
                    if (gesture.window_active) begin
                        gesture.off_while_down  = 1'b1;
                        gesture.release_pending = 1'b0;
                        act.flags.power_pulse   = 1'b1;
                    end else begin
                        gesture.window_active = 1'b1;
                        gesture.window_ticks  = 5'd0;
                        gesture.break_request = 1'b0;
                    end
                end
            end else if (gesture.finger_down) begin
                if (!ev.disp) begin
                    gesture.off_while_down = 1'b0;
                    act.flags.pass_through = 1'b1;
                end else begin
                    gesture.finger_down = 1'b0;
                    if (gesture.home_sent)
                        act.flags.home_release = 1'b1;
                    else
                        gesture.release_pending = 1'b1;
                end
            end else begin
                act.flags.pass_through = 1'b1;
            end
        end else begin
            // plain home key mode
            if (!ev.disp) begin
                act.flags.pass_through = 1'b1;
            end else if (press) begin
                act.flags.vibrate    = 1'b1;
                act.flags.home_press = 1'b1;
            end else begin
                act.flags.home_release = 1'b1;
            end
        end
        return act;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [6:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        store_setting(idx, data);
    endtask

    task automatic add_event(input logic [1:0] cmd, input logic [1:0] key, input logic disp);
        t_sensor_event ev;
        ev.cmd  = cmd;
        ev.key  = key;
        ev.disp = disp;
        queued_events.push_back(ev);
    endtask

    // Fully random word, odd codes included
    task automatic add_noise();
        add_event(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                  1'($urandom_range(0, 1)));
    endtask

    // Ticks carry don't-care key and display bits; sprinkle other events between them
    task automatic add_ticks(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0)
                add_event(ftgf_pkg::CMD_OTHER, 2'($urandom_range(0, 3)),
                          1'($urandom_range(0, 1)));
            add_event(ftgf_pkg::CMD_TICK, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        end
    endtask

    function automatic logic [1:0] press_code();
        return 2'($urandom_range(ftgf_pkg::KEY_PRESS, KEY_ODD));
    endfunction

    // One well-formed gesture with random timing, or a broken one
    task automatic add_tap_gesture();
        int kind;
        int wl;
        int lead;
        wl   = TAP_WINDOW_BASE + int'(wait_cfg);
        kind = $urandom_range(0, 5);
        lead = $urandom_range(0, 4);
        add_event(ftgf_pkg::CMD_KEY, press_code(), 1'b1);
        case (kind)
            0: begin
                // single tap: lift inside the window, then let it run out
                add_ticks(lead);
                add_event(ftgf_pkg::CMD_KEY, ftgf_pkg::KEY_RELEASE, 1'b1);
                add_ticks(wl - lead + $urandom_range(0, 2));
            end
            1: begin
                // hold past the window, so the release follows the home press
                add_ticks(wl + $urandom_range(0, 2));
                add_event(ftgf_pkg::CMD_KEY, ftgf_pkg::KEY_RELEASE, 1'b1);
            end
            2: begin
                // double tap
                add_ticks(lead);
                add_event(ftgf_pkg::CMD_KEY, ftgf_pkg::KEY_RELEASE, 1'b1);
                add_ticks($urandom_range(0, 4));
                add_event(ftgf_pkg::CMD_KEY, press_code(), 1'b1);
                add_ticks($urandom_range(0, 2));
                add_event(ftgf_pkg::CMD_KEY, ftgf_pkg::KEY_RELEASE, 1'b1);
                add_ticks($urandom_range(0, 3));
            end
            3: begin
                // screen goes off while the finger is down
                add_ticks(lead);
                add_event(ftgf_pkg::CMD_KEY, ftgf_pkg::KEY_RELEASE, 1'b0);
                add_ticks($urandom_range(0, wl + 2));
                add_event(ftgf_pkg::CMD_KEY, ftgf_pkg::KEY_RELEASE, 1'b1);
            end
            default: begin
                repeat ($urandom_range(2, 8)) add_noise();
                add_ticks($urandom_range(0, wl + 3));
            end
        endcase
    endtask

    // Hold until every queued word is sent and every action word has come back
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (queued_events.size() != 0 || i_valid || expected_actions.size() != 0);
        repeat (3) @(posedge i_clk);
    endtask

    // Each phase writes all three registers; the later ones cover clamping and the spare index
    task automatic configure_phase(input int p);
        case (p)
            1: begin
                write_reg(ftgf_pkg::CFG_MODE, 7'(ftgf_pkg::MODE_TAP));
                write_reg(ftgf_pkg::CFG_WAIT, 7'(ftgf_pkg::WAIT_MAX));
                write_reg(ftgf_pkg::CFG_VIB, ftgf_pkg::VIB_MAX);
            end
            2: begin
                write_reg(ftgf_pkg::CFG_MODE, 7'(ftgf_pkg::MODE_HOME));
                write_reg(ftgf_pkg::CFG_WAIT, 7'd2);
                write_reg(ftgf_pkg::CFG_VIB, 7'd0);
            end
            3: begin
                write_reg(ftgf_pkg::CFG_MODE, 7'(ftgf_pkg::MODE_PASS));
                write_reg(ftgf_pkg::CFG_WAIT, 7'd5);
                write_reg(ftgf_pkg::CFG_VIB, 7'd45);
            end
            4: begin
                write_reg(ftgf_pkg::CFG_MODE, 7'h7F);
                write_reg(ftgf_pkg::CFG_WAIT, 7'h5F);
                write_reg(ftgf_pkg::CFG_VIB, 7'h7F);
                write_reg(CFG_SPARE, 7'($urandom_range(0, 127)));
            end
            5: begin
                write_reg(ftgf_pkg::CFG_MODE, {5'h1F, ftgf_pkg::MODE_TAP});
                write_reg(ftgf_pkg::CFG_WAIT, 7'd0);
                write_reg(ftgf_pkg::CFG_VIB, 7'($urandom_range(0, 127)));
            end
            default: begin
                write_reg(ftgf_pkg::CFG_MODE, 7'($urandom_range(0, 127)));
                write_reg(ftgf_pkg::CFG_WAIT, 7'($urandom_range(0, 127)));
                write_reg(ftgf_pkg::CFG_VIB, 7'($urandom_range(0, 127)));
                if ($urandom_range(0, 1) == 1)
                    write_reg(CFG_SPARE, 7'($urandom_range(0, 127)));
            end
        endcase
    endtask

    // Driver: present the next queued word, hold it while stalled, predict at acceptance
    always @(posedge i_clk) begin : word_driver
        t_sensor_event nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                expected_actions.push_back(predict_gesture(word_on_bus));
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                    i_valid <= 1'b0;
                end else if (queued_events.size() != 0) begin
                    nxt          = queued_events.pop_front();
                    word_on_bus  = nxt;
                    i_cmd        <= nxt.cmd;
                    i_key_value  <= nxt.key;
                    i_display_on <= nxt.disp;
                    i_valid      <= 1'b1;
                    send_gap     = sender_idles ? idle_len() : 0;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Checker: compare each accepted action word with the oldest prediction; drive stalls
    always @(posedge i_clk) begin : action_monitor
        t_key_action want;
        t_key_action got;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got.flags.pass_through = o_pass_through;
                got.flags.home_press   = o_home_press;
                got.flags.home_release = o_home_release;
                got.flags.power_pulse  = o_power_pulse;
                got.flags.vibrate      = o_vibrate;
                got.strength           = o_vibrate_strength;
                if (expected_actions.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"unexpected action word: ",
                                  "pass=%0b hp=%0b hr=%0b pwr=%0b vib=%0b str=%0d"},
                                 got.flags.pass_through, got.flags.home_press,
                                 got.flags.home_release, got.flags.power_pulse,
                                 got.flags.vibrate, got.strength);
                end else begin
                    want = expected_actions.pop_front();
                    if (got.flags.pass_through !== want.flags.pass_through ||
                        got.flags.home_press   !== want.flags.home_press   ||
                        got.flags.home_release !== want.flags.home_release ||
                        got.flags.power_pulse  !== want.flags.power_pulse  ||
                        got.flags.vibrate      !== want.flags.vibrate      ||
                        got.strength           !== want.strength) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"word %0d: ",
                                      "exp pass=%0b hp=%0b hr=%0b pwr=%0b vib=%0b str=%0d",
                                      " / got pass=%0b hp=%0b hr=%0b pwr=%0b vib=%0b str=%0d"},
                                     results_seen,
                                     want.flags.pass_through, want.flags.home_press,
                                     want.flags.home_release, want.flags.power_pulse,
                                     want.flags.vibrate, want.strength,
                                     got.flags.pass_through, got.flags.home_press,
                                     got.flags.home_release, got.flags.power_pulse,
                                     got.flags.vibrate, got.strength);
                    end
                end
                results_seen++;
            end
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
                i_stall <= 1'b1;
            end else begin
                stall_left = receiver_stalls ? idle_len() : 0;
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int target;
        // power-on settings of the shadow copy
        mode_cfg = ftgf_pkg::MODE_RESET;
        wait_cfg = ftgf_pkg::WAIT_RESET;
        vib_cfg  = ftgf_pkg::VIB_RESET;
        gesture  = ftgf_pkg::STATE_RESET;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: shortest window so expiry is cheap to reach
        write_reg(ftgf_pkg::CFG_WAIT, 7'd0);
        @(negedge i_clk);
        add_event(ftgf_pkg::CMD_OTHER, ftgf_pkg::KEY_RELEASE, 1'b0);
        add_event(CMD_SPARE, KEY_ODD, 1'b1);
        // press with screen off passes
        add_event(ftgf_pkg::CMD_KEY, ftgf_pkg::KEY_PRESS, 1'b0);
        // untracked release passes
        add_event(ftgf_pkg::CMD_KEY, ftgf_pkg::KEY_RELEASE, 1'b1);
        // tick with no window open
        add_event(ftgf_pkg::CMD_TICK, KEY_ODD, 1'b1);
        // autorepeat opens the window
        add_event(ftgf_pkg::CMD_KEY, ftgf_pkg::KEY_REPEAT, 1'b1);
        // lift: release pending
        add_event(ftgf_pkg::CMD_KEY, ftgf_pkg::KEY_RELEASE, 1'b1);
        // last tick expires the window: press plus release
        for (int i = 0; i < TAP_WINDOW_BASE; i++)
            add_event(ftgf_pkg::CMD_TICK, ftgf_pkg::KEY_RELEASE, 1'b0);
        add_event(ftgf_pkg::CMD_KEY, ftgf_pkg::KEY_PRESS, 1'b1);
        // second press: power pulse
        add_event(ftgf_pkg::CMD_KEY, KEY_ODD, 1'b1);
        // window closes silently
        add_event(ftgf_pkg::CMD_TICK, ftgf_pkg::KEY_PRESS, 1'b1);
        // tracked release, screen off
        add_event(ftgf_pkg::CMD_KEY, ftgf_pkg::KEY_RELEASE, 1'b0);
        add_event(ftgf_pkg::CMD_KEY, ftgf_pkg::KEY_RELEASE, 1'b1);
        add_event(ftgf_pkg::CMD_OTHER, KEY_ODD, 1'b1);
        wait_drained();

        // Random phases, each under its own settings, drained before the next write
        for (int p = 1; p <= NUM_PHASES; p++) begin
            configure_phase(p);
            @(negedge i_clk);
            sender_idles    = (p % 4 != 3);
            receiver_stalls = (p % 3 != 2);
            target = PHASE_WORDS;
            while (queued_events.size() < target) begin
                if ($urandom_range(0, 99) < 85)
                    add_tap_gesture();
                else
                    add_noise();
            end
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && expected_actions.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/ftgf_pkg.sv
rtl/ftgf_step.sv
rtl/fingerprint_tap_gesture_filter.sv
tb/tb_fingerprint_tap_gesture_filter.sv
